FILE: rtl/core/sros_pkg.sv
// Shared types, widths and constants for the success-ranked order selector.
package sros_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_SUCCESS = 2'd0,
        KIND_ADJUST  = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_STAMP   = 2'd3
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MIN      = 2'd1;
    localparam logic [1:0] CFG_MASK     = 2'd2;

    // Field widths
    localparam int KIND_W     = 2;
    localparam int SLOT_IN_W  = 8;
    localparam int TIME_W     = 63;
    localparam int INTERVAL_W = 40;
    localparam int MIN_W      = 16;
    localparam int MASK_W     = 32;
    localparam int RANK_W     = 2;
    localparam int RANKS      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // Stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    // Defaults for module parameters
    localparam int SLOTS_DEF      = 4;
    localparam int COUNT_BITS_DEF = 32;

    // Register reset values
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 40'd600000000;
    localparam logic [MIN_W-1:0]      MIN_RST      = 16'd50;
    localparam logic [MASK_W-1:0]     MASK_RST     = 32'h1FFF_E000;

endpackage

FILE: rtl/core/success_ranked_order_selector.sv
// Success-ranked service order selector: counters, gated reorder and result stage.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+------------------------------------------
//   s_      | in  | tvalid / tready  | tuser: kind; tdata: slot, now_us
//   m_      | out | tvalid / tready  | tdata: ranks, mask_out, adjusted, changed
//   cfg_    | in  | we (no wait)     | index, data
//
// Each item passes through the input register and then the result register;
// one item per cycle sustained while m_tready does not stall, set by the
// combinational next state of the counters and the compare-and-swap network.
// Reset clears counts, restores order 0..SLOTS-1, timestamp zero and the
// register defaults. A stall on m_tready backs up through both registers.
module success_ranked_order_selector #(
    parameter int SLOTS      = sros_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = sros_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sros_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] slot, [70:8] now_us
    input  logic [sros_pkg::KIND_W-1:0]          s_tuser,   // [1:0] kind
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sros_pkg::OUT_DATA_W-1:0]      m_tdata,   // [1:0] rank_first,
                                                            // [3:2] rank_second,
                                                            // [5:4] rank_third,
                                                            // [7:6] rank_fourth,
                                                            // [39:8] mask_out,
                                                            // [40] adjusted,
                                                            // [41] order_changed
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [sros_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sros_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W  = (COUNT_BITS > sros_pkg::MIN_W) ? COUNT_BITS : sros_pkg::MIN_W;

    // configuration
    logic [sros_pkg::INTERVAL_W-1:0] interval_reg;
    logic [sros_pkg::MIN_W-1:0]      min_shares_reg;
    logic [sros_pkg::MASK_W-1:0]     roll_mask_reg;

    // block state
    logic [COUNT_BITS-1:0]       hit_counts_reg [SLOTS];
    logic [COUNT_BITS-1:0]       hit_counts_next [SLOTS];
    logic [COUNT_BITS-1:0]       hit_total_reg;
    logic [COUNT_BITS-1:0]       hit_total_next;
    logic [SLOT_W-1:0]           order_reg [SLOTS];
    logic [SLOT_W-1:0]           order_next [SLOTS];
    logic [sros_pkg::TIME_W-1:0] last_adjust_reg;
    logic [sros_pkg::TIME_W-1:0] last_adjust_next;

    // input register
    logic                           in_valid_reg;
    logic                           in_valid_next;
    sros_pkg::kind_t                in_kind_reg;
    logic [sros_pkg::SLOT_IN_W-1:0] in_slot_reg;
    logic [sros_pkg::TIME_W-1:0]    in_now_reg;

    // result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [sros_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [sros_pkg::OUT_DATA_W-1:0] out_data_next;

    logic out_free;
    logic fire;
    logic slot_ok;
    logic elapsed;
    logic enough;
    logic adjust_ok;
    logic changed;
    logic [sros_pkg::TIME_W-1:0] since_stamp;

    // ranking network outputs
    logic [SLOT_W-1:0]     rank_idx [SLOTS];
    logic [COUNT_BITS-1:0] rank_cnt [SLOTS];

    logic [sros_pkg::RANK_W-1:0] rank_out [sros_pkg::RANKS];

    // Pipeline handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign fire     = in_valid_reg && out_free;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_free ? fire : out_valid_reg;

    // Gates for a reorder
    assign slot_ok     = in_slot_reg < sros_pkg::SLOT_IN_W'(SLOTS);
    assign since_stamp = in_now_reg - last_adjust_reg;
    assign elapsed     = (in_now_reg >= last_adjust_reg) &&
                         (since_stamp >= sros_pkg::TIME_W'(interval_reg));
    assign enough      = CMP_W'(hit_total_reg) >= CMP_W'(min_shares_reg);
    assign adjust_ok   = (in_kind_reg == sros_pkg::KIND_ADJUST) && elapsed && enough;

    // Rank slots by descending count; indexes travel with their counts
    always_comb
    begin
        logic [SLOT_W-1:0]     tmp_idx;
        logic [COUNT_BITS-1:0] tmp_cnt;
        tmp_idx = '0;
        tmp_cnt = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rank_idx[i] = SLOT_W'(i);
            rank_cnt[i] = hit_counts_reg[i];
        end
        for (int i = 0; i < SLOTS - 1; i++)
        begin
            for (int j = i + 1; j < SLOTS; j++)
            begin
                if (rank_cnt[j] > rank_cnt[i])
                begin
                    tmp_idx     = rank_idx[i];
                    tmp_cnt     = rank_cnt[i];
                    rank_idx[i] = rank_idx[j];
                    rank_cnt[i] = rank_cnt[j];
                    rank_idx[j] = tmp_idx;
                    rank_cnt[j] = tmp_cnt;
                end
            end
        end
    end

    // Detect a change of order
    always_comb
    begin
        changed = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (order_reg[i] != rank_idx[i])
            begin
                changed = 1'b1;
            end
        end
    end

    // Next state for one item
    always_comb
    begin
        hit_counts_next  = hit_counts_reg;
        hit_total_next   = hit_total_reg;
        order_next       = order_reg;
        last_adjust_next = last_adjust_reg;
        case (in_kind_reg)
            sros_pkg::KIND_SUCCESS:
            begin
                if (slot_ok)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (in_slot_reg == sros_pkg::SLOT_IN_W'(i) &&
                            hit_counts_reg[i] != '1)
                        begin
                            hit_counts_next[i] = hit_counts_reg[i] + COUNT_BITS'(1);
                        end
                    end
                    if (hit_total_reg != '1)
                    begin
                        hit_total_next = hit_total_reg + COUNT_BITS'(1);
                    end
                end
            end
            sros_pkg::KIND_ADJUST:
            begin
                if (adjust_ok)
                begin
                    order_next = rank_idx;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        hit_counts_next[i] = '0;
                    end
                    hit_total_next   = '0;
                    last_adjust_next = in_now_reg;
                end
            end
            sros_pkg::KIND_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    hit_counts_next[i] = '0;
                end
                hit_total_next = '0;
            end
            sros_pkg::KIND_STAMP:
            begin
                last_adjust_next = in_now_reg;
            end
            default:
            begin
                last_adjust_next = last_adjust_reg;
            end
        endcase
    end

    // Rank fields; positions past the slot count read zero
    genvar p;
    generate
        for (p = 0; p < sros_pkg::RANKS; p++)
        begin : g_rank
            if (p < SLOTS)
            begin : g_used
                assign rank_out[p] = sros_pkg::RANK_W'(order_next[p]);
            end
            else
            begin : g_unused
                assign rank_out[p] = '0;
            end
        end
    endgenerate

    // Pack the result item
    assign out_data_next = {6'd0,
                            adjust_ok && changed,
                            adjust_ok,
                            roll_mask_reg,
                            rank_out[3], rank_out[2], rank_out[1], rank_out[0]};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= sros_pkg::INTERVAL_RST;
            min_shares_reg <= sros_pkg::MIN_RST;
            roll_mask_reg  <= sros_pkg::MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sros_pkg::CFG_INTERVAL: interval_reg   <= cfg_data[sros_pkg::INTERVAL_W-1:0];
                sros_pkg::CFG_MIN:      min_shares_reg <= cfg_data[sros_pkg::MIN_W-1:0];
                sros_pkg::CFG_MASK:     roll_mask_reg  <= cfg_data[sros_pkg::MASK_W-1:0];
                default:                roll_mask_reg  <= roll_mask_reg;
            endcase
        end
    end

    // Block state and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                hit_counts_reg[i] <= '0;
                order_reg[i]      <= SLOT_W'(i);
            end
            hit_total_reg   <= '0;
            last_adjust_reg <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                hit_counts_reg  <= hit_counts_next;
                hit_total_reg   <= hit_total_next;
                order_reg       <= order_next;
                last_adjust_reg <= last_adjust_next;
            end
        end
    end

    // Payload registers: capture on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= sros_pkg::kind_t'(s_tuser);
            in_slot_reg <= s_tdata[sros_pkg::SLOT_IN_W-1:0];
            in_now_reg  <= s_tdata[sros_pkg::SLOT_IN_W +: sros_pkg::TIME_W];
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A passed adjust clears the total and restamps the time
    a_adjust_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && adjust_ok) |=> (hit_total_reg == '0 && last_adjust_reg == $past(in_now_reg)))
        else $error("adjust did not clear statistics or restamp");

    // The total never trails the slot 0 counter
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hit_total_reg >= hit_counts_reg[0])
        else $error("total below slot counter");

    // A changed order is only reported with an adjust
    a_changed_adjusted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[41]) |-> m_tdata[40])
        else $error("order change without adjust");

    // The first order entry only moves on a passed adjust
    a_order_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !adjust_ok) |=> (order_reg[0] == $past(order_reg[0])))
        else $error("order moved without adjust");

endmodule
